// ===== rtl/core/dltq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the timer queue.
package dltq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int TICK_BITS  = 32;
   localparam int IDX_W      = $clog2(NUM_TIMERS);
   localparam int LINK_W     = IDX_W + 1;

   // link value that marks the end of the list
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_TIMERS);

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_CREATE     = 3'd1,
      OP_ENABLE     = 3'd2,
      OP_DISABLE    = 3'd3,
      OP_DELETE     = 3'd4,
      OP_SET_REPEAT = 3'd5,
      OP_SET_SINGLE = 3'd6,
      OP_NOP        = 3'd7
   } op_type;

   // datapath step commanded by the controller
   typedef enum logic [4:0] {
      DP_IDLE,
      DP_LOAD,
      DP_DISPATCH,
      DP_CR_SET,
      DP_TK_DEC,
      DP_TK_POP1,
      DP_TK_POP2,
      DP_AC_START,
      DP_AC_WALK,
      DP_AC_LINK1,
      DP_AC_LINK2,
      DP_AC_LINK3,
      DP_UL_START,
      DP_UL_WALK,
      DP_UL_RD,
      DP_UL_FIX,
      DP_EMIT_DONE,
      DP_EMIT_EXP,
      DP_EMIT_NONE
   } step_type;

   typedef struct packed {
      op_type op;
      logic   id_ok;
      logic   head_valid;
      logic   rem_zero;
      logic   cur_valid;
      logic   cur_is_tgt;
      logic   walk_ge;
      logic   tgt_enabled;
      logic   tgt_active;
      logic   tgt_repeat;
   } dp_status_type;

endpackage

// ===== rtl/core/delta_list_timer_queue.sv =====
// Delta-list timer queue: sixteen timers, tick and command transactions.
// A simple command strobes its result after dispatch; enable walks the list and relinks the
// timer, disable and delete walk it and unlink the timer, and create may unlink and then relink.
// A tick decrements the head counter; when it reaches zero, the expired timers are popped and
// reported in turn, and each repeating timer is put back into the list.
// Results are registered strobes; busy stays high until the last one is issued.
// Reset (synchronous) empties the list and clears all flags; tables hold junk until written.
module delta_list_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_reload_ticks,
   input  logic        req_repeat_mode,
   input  logic        req_start_enabled,
   output logic        rsp_valid,
   output logic        rsp_event_kind,
   output logic [3:0]  rsp_timer_id_res,
   output logic        rsp_last
);
   import dltq_pkg::*;

   dp_status_type status;
   step_type      step;

   dltq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .step   (step)
   );

   dltq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .req_operation     (req_operation),
      .req_timer_id      (req_timer_id),
      .req_reload_ticks  (req_reload_ticks),
      .req_repeat_mode   (req_repeat_mode),
      .req_start_enabled (req_start_enabled),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_timer_id_res  (rsp_timer_id_res),
      .rsp_last          (rsp_last)
   );

   // an accepted transaction keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // the block only goes idle on the final result of a transaction
   a_idle_on_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_valid && rsp_last))
      else $error("went idle without a final result");

   // a result that is not the final one leaves the block working
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("intermediate result while idle");

   // a command result, or a tick's no-expiry result, is issued only once the block is idle
   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_event_kind && busy) |-> 1'b0)
      else $error("command result issued while still busy");

endmodule

// ===== rtl/core/dltq_datapath.sv =====
// Timer tables, list registers and result registers, driven one step at a time.
module dltq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  dltq_pkg::step_type      step,
   input  logic [2:0]              req_operation,
   input  logic [3:0]              req_timer_id,
   input  logic [31:0]             req_reload_ticks,
   input  logic                    req_repeat_mode,
   input  logic                    req_start_enabled,
   output dltq_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output logic                    rsp_event_kind,
   output logic [3:0]              rsp_timer_id_res,
   output logic                    rsp_last
);
   import dltq_pkg::*;

   // timer tables
   logic [TICK_BITS-1:0] delta_ff  [NUM_TIMERS];
   logic [TICK_BITS-1:0] reload_ff [NUM_TIMERS];
   logic [LINK_W-1:0]    next_ff   [NUM_TIMERS];

   logic [NUM_TIMERS-1:0] repeat_ff, repeat_in;
   logic [NUM_TIMERS-1:0] enabled_ff, enabled_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;

   // transaction fields
   op_type        op_ff, op_in;
   logic [3:0]    tid_ff, tid_in;
   logic [31:0]   reload_req_ff, reload_req_in;
   logic          mode_ff, mode_in;
   logic          sten_ff, sten_in;

   // list walk registers
   logic [IDX_W-1:0]     tgt_ff, tgt_in;
   logic [LINK_W-1:0]    cur_ff, cur_in;
   logic [LINK_W-1:0]    prev_ff, prev_in;
   logic [LINK_W-1:0]    nxt_ff, nxt_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   logic [LINK_W-1:0]    head_ff, head_in;
   logic [TICK_BITS-1:0] head_rem_ff, head_rem_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff, rsp_kind_in;
   logic [3:0] rsp_id_ff, rsp_id_in;
   logic       rsp_last_ff, rsp_last_in;

   // table write ports
   logic                 delta_we, next_we, reload_we;
   logic [IDX_W-1:0]     delta_wa, next_wa;
   logic [TICK_BITS-1:0] delta_wd;
   logic [LINK_W-1:0]    next_wd;

   // shared read port
   logic [IDX_W-1:0]     rd_addr;
   logic [TICK_BITS-1:0] rd_delta, rd_reload;
   logic [LINK_W-1:0]    rd_next;

   logic                 head_valid, cur_valid, prev_valid, nxt_valid, id_ok;
   logic [TICK_BITS-1:0] reload_sat;

   assign head_valid = head_ff < LINK_NONE;
   assign cur_valid  = cur_ff < LINK_NONE;
   assign prev_valid = prev_ff < LINK_NONE;
   assign nxt_valid  = nxt_ff < LINK_NONE;
   assign id_ok      = 32'(tid_ff) < 32'(NUM_TIMERS);

   // saturate the requested period to the tick width, zero counts as one
   always_comb begin
      if ((64'(reload_req_ff) >> TICK_BITS) != 64'd0) begin
         reload_sat = '1;
      end else begin
         reload_sat = TICK_BITS'(reload_req_ff);
      end
      if (reload_sat == '0) begin
         reload_sat = TICK_BITS'(1);
      end
   end

   // pick the table entry this step looks at
   always_comb begin
      unique case (step)
         DP_AC_WALK, DP_AC_LINK2, DP_UL_WALK:    rd_addr = cur_ff[IDX_W-1:0];
         DP_AC_LINK3, DP_TK_POP1, DP_TK_POP2:    rd_addr = head_ff[IDX_W-1:0];
         DP_UL_FIX:                              rd_addr = nxt_ff[IDX_W-1:0];
         default:                                rd_addr = tgt_ff;
      endcase
   end

   assign rd_delta  = delta_ff[rd_addr];
   assign rd_next   = next_ff[rd_addr];
   assign rd_reload = reload_ff[rd_addr];

   // status back to the controller
   always_comb begin
      status.op          = op_ff;
      status.id_ok       = id_ok;
      status.head_valid  = head_valid;
      status.rem_zero    = head_rem_ff == '0;
      status.cur_valid   = cur_valid;
      status.cur_is_tgt  = cur_ff == LINK_W'(tgt_ff);
      status.walk_ge     = ticks_ff >= rd_delta;
      status.tgt_enabled = enabled_ff[tgt_ff];
      status.tgt_active  = active_ff[tgt_ff];
      status.tgt_repeat  = repeat_ff[tgt_ff];
   end

   // next state of every register for the commanded step
   always_comb begin
      op_in         = op_ff;
      tid_in        = tid_ff;
      reload_req_in = reload_req_ff;
      mode_in       = mode_ff;
      sten_in       = sten_ff;
      tgt_in        = tgt_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      nxt_in        = nxt_ff;
      ticks_in      = ticks_ff;
      head_in       = head_ff;
      head_rem_in   = head_rem_ff;
      repeat_in     = repeat_ff;
      enabled_in    = enabled_ff;
      active_in     = active_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      delta_we      = 1'b0;
      delta_wa      = tgt_ff;
      delta_wd      = ticks_ff;
      next_we       = 1'b0;
      next_wa       = tgt_ff;
      next_wd       = cur_ff;
      reload_we     = 1'b0;
      unique case (step)
         DP_IDLE: begin
         end
         DP_LOAD: begin
            op_in         = op_type'(req_operation);
            tid_in        = req_timer_id;
            reload_req_in = req_reload_ticks;
            mode_in       = req_repeat_mode;
            sten_in       = req_start_enabled;
            tgt_in        = IDX_W'(req_timer_id);
         end
         DP_DISPATCH: begin
            if (id_ok) begin
               unique case (op_ff)
                  OP_ENABLE:             enabled_in[tgt_ff] = 1'b1;
                  OP_DISABLE, OP_DELETE: enabled_in[tgt_ff] = 1'b0;
                  OP_SET_REPEAT:         repeat_in[tgt_ff] = 1'b1;
                  OP_SET_SINGLE:         repeat_in[tgt_ff] = 1'b0;
                  default: begin
                  end
               endcase
            end
         end
         DP_CR_SET: begin
            reload_we          = 1'b1;
            repeat_in[tgt_ff]  = mode_ff;
            enabled_in[tgt_ff] = sten_ff;
            active_in[tgt_ff]  = 1'b0;
         end
         DP_TK_DEC: begin
            head_rem_in = head_rem_ff - TICK_BITS'(1);
         end
         DP_TK_POP1: begin
            tgt_in                        = head_ff[IDX_W-1:0];
            active_in[head_ff[IDX_W-1:0]] = 1'b0;
            head_in                       = rd_next;
         end
         DP_TK_POP2: begin
            head_rem_in = head_valid ? rd_delta : '0;
         end
         DP_AC_START: begin
            ticks_in = (rd_reload == '0) ? TICK_BITS'(1) : rd_reload;
            cur_in   = head_ff;
            prev_in  = LINK_NONE;
            // spill the head counter into the head's delta before the walk
            if (head_valid && enabled_ff[tgt_ff] && !active_ff[tgt_ff]) begin
               delta_we = 1'b1;
               delta_wa = head_ff[IDX_W-1:0];
               delta_wd = head_rem_ff;
            end
         end
         DP_AC_WALK: begin
            if (cur_valid && (ticks_ff >= rd_delta)) begin
               ticks_in = ticks_ff - rd_delta;
               prev_in  = cur_ff;
               cur_in   = rd_next;
            end
         end
         DP_AC_LINK1: begin
            delta_we = 1'b1;
            delta_wa = tgt_ff;
            delta_wd = ticks_ff;
            next_we  = 1'b1;
            next_wa  = tgt_ff;
            next_wd  = cur_ff;
         end
         DP_AC_LINK2: begin
            if (prev_valid) begin
               next_we = 1'b1;
               next_wa = prev_ff[IDX_W-1:0];
               next_wd = LINK_W'(tgt_ff);
            end else begin
               head_in = LINK_W'(tgt_ff);
            end
            if (cur_valid) begin
               delta_we = 1'b1;
               delta_wa = cur_ff[IDX_W-1:0];
               delta_wd = rd_delta - ticks_ff;
            end
            active_in[tgt_ff] = 1'b1;
         end
         DP_AC_LINK3: begin
            head_rem_in = rd_delta;
         end
         DP_UL_START: begin
            cur_in  = head_ff;
            prev_in = LINK_NONE;
         end
         DP_UL_WALK: begin
            if (cur_valid && (cur_ff != LINK_W'(tgt_ff))) begin
               prev_in = cur_ff;
               cur_in  = rd_next;
            end else begin
               active_in[tgt_ff] = 1'b0;
            end
         end
         DP_UL_RD: begin
            nxt_in   = rd_next;
            ticks_in = rd_delta;
         end
         DP_UL_FIX: begin
            // hand the removed delay on to the successor
            if (!prev_valid) begin
               head_in     = nxt_ff;
               head_rem_in = nxt_valid ? (head_rem_ff + rd_delta) : '0;
            end else begin
               next_we = 1'b1;
               next_wa = prev_ff[IDX_W-1:0];
               next_wd = nxt_ff;
               if (nxt_valid) begin
                  delta_we = 1'b1;
                  delta_wa = nxt_ff[IDX_W-1:0];
                  delta_wd = rd_delta + ticks_ff;
               end
            end
         end
         DP_EMIT_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = 1'b0;
            rsp_id_in    = tid_ff;
            rsp_last_in  = 1'b1;
         end
         DP_EMIT_EXP: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = 1'b1;
            rsp_id_in    = 4'(tgt_ff);
            rsp_last_in  = !(head_valid && (head_rem_ff == '0));
         end
         DP_EMIT_NONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = 1'b0;
            rsp_id_in    = 4'd0;
            rsp_last_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff    <= '0;
         enabled_ff   <= '0;
         active_ff    <= '0;
         head_ff      <= LINK_NONE;
         head_rem_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         repeat_ff    <= repeat_in;
         enabled_ff   <= enabled_in;
         active_ff    <= active_in;
         head_ff      <= head_in;
         head_rem_ff  <= head_rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tid_ff        <= tid_in;
      reload_req_ff <= reload_req_in;
      mode_ff       <= mode_in;
      sten_ff       <= sten_in;
      tgt_ff        <= tgt_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      nxt_ff        <= nxt_in;
      ticks_ff      <= ticks_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // table writes
   always_ff @(posedge clock) begin
      if (delta_we) begin
         delta_ff[delta_wa] <= delta_wd;
      end
      if (next_we) begin
         next_ff[next_wa] <= next_wd;
      end
      if (reload_we) begin
         reload_ff[tgt_ff] <= reload_sat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_timer_id_res = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== rtl/core/dltq_ctrl.sv =====
// Sequencer that walks the timer list one link per cycle to add or drop timers.
module dltq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  dltq_pkg::dp_status_type status,
   output dltq_pkg::step_type      step
);
   import dltq_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE      = 19'h00001,
      S_DISPATCH  = 19'h00002,
      S_CR_SET    = 19'h00004,
      S_TK_DEC    = 19'h00008,
      S_TK_TEST   = 19'h00010,
      S_TK_POP1   = 19'h00020,
      S_TK_POP2   = 19'h00040,
      S_AC_START  = 19'h00080,
      S_AC_WALK   = 19'h00100,
      S_AC_LINK1  = 19'h00200,
      S_AC_LINK2  = 19'h00400,
      S_AC_LINK3  = 19'h00800,
      S_UL_START  = 19'h01000,
      S_UL_WALK   = 19'h02000,
      S_UL_RD     = 19'h04000,
      S_UL_FIX    = 19'h08000,
      S_EMIT_DONE = 19'h10000,
      S_EMIT_EXP  = 19'h20000,
      S_EMIT_NONE = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   state_type ac_return, ul_return;

   // where insertion and removal hand control back
   assign ac_return = (status.op == OP_TICK) ? S_EMIT_EXP : S_EMIT_DONE;
   assign ul_return = (status.op == OP_CREATE) ? S_CR_SET : S_EMIT_DONE;

   always_comb begin
      state_in = state_ff;
      step     = DP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               step     = DP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            step = DP_DISPATCH;
            if (status.op == OP_TICK) begin
               state_in = status.head_valid ? S_TK_DEC : S_EMIT_NONE;
            end else if (!status.id_ok) begin
               state_in = S_EMIT_DONE;
            end else begin
               unique case (status.op)
                  OP_CREATE:             state_in = status.tgt_active ? S_UL_START : S_CR_SET;
                  OP_ENABLE:             state_in = S_AC_START;
                  OP_DISABLE, OP_DELETE: state_in = status.tgt_active ? S_UL_START : S_EMIT_DONE;
                  default:               state_in = S_EMIT_DONE;
               endcase
            end
         end
         S_CR_SET: begin
            step     = DP_CR_SET;
            state_in = S_AC_START;
         end
         S_TK_DEC: begin
            step     = DP_TK_DEC;
            state_in = S_TK_TEST;
         end
         S_TK_TEST: begin
            state_in = status.rem_zero ? S_TK_POP1 : S_EMIT_NONE;
         end
         S_TK_POP1: begin
            step     = DP_TK_POP1;
            state_in = S_TK_POP2;
         end
         S_TK_POP2: begin
            step     = DP_TK_POP2;
            state_in = status.tgt_repeat ? S_AC_START : S_EMIT_EXP;
         end
         S_AC_START: begin
            step     = DP_AC_START;
            state_in = (status.tgt_enabled && !status.tgt_active) ? S_AC_WALK : ac_return;
         end
         S_AC_WALK: begin
            // advance while the remaining delay covers the next entry
            step     = DP_AC_WALK;
            state_in = (status.cur_valid && status.walk_ge) ? S_AC_WALK : S_AC_LINK1;
         end
         S_AC_LINK1: begin
            step     = DP_AC_LINK1;
            state_in = S_AC_LINK2;
         end
         S_AC_LINK2: begin
            step     = DP_AC_LINK2;
            state_in = S_AC_LINK3;
         end
         S_AC_LINK3: begin
            step     = DP_AC_LINK3;
            state_in = ac_return;
         end
         S_UL_START: begin
            step     = DP_UL_START;
            state_in = S_UL_WALK;
         end
         S_UL_WALK: begin
            step = DP_UL_WALK;
            priority if (status.cur_valid && !status.cur_is_tgt) begin
               state_in = S_UL_WALK;
            end else if (status.cur_valid) begin
               state_in = S_UL_RD;
            end else begin
               state_in = ul_return;
            end
         end
         S_UL_RD: begin
            step     = DP_UL_RD;
            state_in = S_UL_FIX;
         end
         S_UL_FIX: begin
            step     = DP_UL_FIX;
            state_in = ul_return;
         end
         S_EMIT_DONE: begin
            step     = DP_EMIT_DONE;
            state_in = S_IDLE;
         end
         S_EMIT_EXP: begin
            // drop back to idle after the final expiry, else pop again
            step     = DP_EMIT_EXP;
            state_in = (status.head_valid && status.rem_zero) ? S_TK_POP1 : S_IDLE;
         end
         S_EMIT_NONE: begin
            step     = DP_EMIT_NONE;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule
